/* design/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [15:0] patient_id;
    logic [6:0]  age;
    logic [7:0]  organ;
    logic [7:0]  severity;
  } rec_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

/* design/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: keeps, loads the new item, or shifts from
// a neighbor.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  rec_t       new_rec,
  input  rec_t       left_rec,
  input  logic       left_ge,
  input  rec_t       right_rec,
  output rec_t       rec,
  output logic       ge
);

  rec_t rec_r;
  rec_t rec_nxt;

  // stored entry ranks strictly ahead of the new item
  assign ge = occupied && (rec_r.severity > new_rec.severity);

  always_comb begin
    rec_nxt = rec_r;
    if (ctrl.ins) begin
      if (!ge) begin
        rec_nxt = left_ge ? new_rec : left_rec;
      end
    end else if (ctrl.rem) begin
      rec_nxt = right_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

/* design/sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue kept sorted by descending severity in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per item:
//   insert, remove head, or clear. Result channel (out_valid/out_ready)
//   returns one item per operation with status, the removed record (zero
//   unless a remove succeeded) and the occupancy after the operation.
//   Timing: the result is registered and valid in the cycle after accept.
//   Throughput: one item per cycle while out_ready is high; every cell
//   compares its severity with the new item in parallel and shifts from its
//   neighbor in the same cycle. Equal severities: newest insert served first.
//   Reset: the queue is empty, no result is pending; slot contents are
//   undefined until written.
//   Stall: the result sits in an output register; in_ready follows
//   out_ready while a result waits, so an item can enter in the same cycle
//   the pending result is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_patient_id,
  input  logic [6:0]  in_age,
  input  logic [7:0]  in_organ,
  input  logic [7:0]  in_severity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_patient_id,
  output logic [6:0]  out_age,
  output logic [7:0]  out_organ,
  output logic [7:0]  out_severity,
  output logic [4:0]  out_occupancy
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int ExtW = (CntW > 5) ? CntW : 5;

  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic            out_valid_r;
  logic [1:0]      status_r;
  logic [1:0]      status_nxt;
  rec_t            res_r;
  rec_t            res_nxt;
  logic [ExtW-1:0] occ_r;

  logic       accept;
  logic       is_full;
  logic       is_empty;
  cell_ctrl_t ctrl;
  rec_t       new_rec;

  rec_t cell_rec [QUEUE_DEPTH];
  logic cell_ge  [QUEUE_DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == CntW'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);

  assign new_rec.patient_id = in_patient_id;
  assign new_rec.age        = in_age;
  assign new_rec.organ      = in_organ;
  assign new_rec.severity   = in_severity;

  assign ctrl.ins = accept && (in_mode == MODE_INSERT) && !is_full;
  assign ctrl.rem = accept && (in_mode == MODE_REMOVE) && !is_empty;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      rec_t left_rec;
      logic left_ge;
      rec_t right_rec;
      if (gi == 0) begin : g_head
        assign left_rec = new_rec;
        assign left_ge  = 1'b1;
      end else begin : g_mid
        assign left_rec = cell_rec[gi-1];
        assign left_ge  = cell_ge[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign right_rec = cell_rec[gi];
      end else begin : g_body
        assign right_rec = cell_rec[gi+1];
      end
      spq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occupied  (CntW'(gi) < count_r),
        .new_rec   (new_rec),
        .left_rec  (left_rec),
        .left_ge   (left_ge),
        .right_rec (right_rec),
        .rec       (cell_rec[gi]),
        .ge        (cell_ge[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    res_nxt    = '0;
    case (in_mode)
      MODE_INSERT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CntW'(1);
        end
      end
      MODE_REMOVE: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          res_nxt   = cell_rec[0];
          count_nxt = count_r - CntW'(1);
        end
      end
      MODE_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      occ_r    <= ExtW'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_patient_id = res_r.patient_id;
  assign out_age        = res_r.age;
  assign out_organ      = res_r.organ;
  assign out_severity   = res_r.severity;
  assign out_occupancy  = occ_r[4:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QUEUE_DEPTH))
    else $error("stored count exceeds depth");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CntW'(2)) |-> (cell_rec[0].severity >= cell_rec[1].severity))
    else $error("head pair out of order");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == MODE_CLEAR)) |=> (count_r == '0))
    else $error("clear left entries");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |->
      (out_severity == '0 && out_occupancy == '0))
    else $error("empty result carries data");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == MODE_INSERT) && is_full) |=> (count_r == CntW'(QUEUE_DEPTH)))
    else $error("insert on full changed count");

endmodule

/* bench/tb_sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_unit
// Drives insert, remove and clear items through the queue under random
// idling on both sides, including one long receiver hold-off. A local
// ward model predicts each result. Results are checked field by field in
// order, first for a short directed table and then for a long random run.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_unit
  import spq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QDEPTH       = 16;
  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [1:0] mode;
    rec_t       rec;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    rec_t       rec;
    logic [4:0] occupancy;
  } result_t;

  typedef struct {
    item_t   item;
    bit      typed;
    result_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [15:0] in_patient_id;
  logic [6:0]  in_age;
  logic [7:0]  in_organ;
  logic [7:0]  in_severity;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [15:0] out_patient_id;
  logic [6:0]  out_age;
  logic [7:0]  out_organ;
  logic [7:0]  out_severity;
  logic [4:0]  out_occupancy;

  rec_t    ward [QDEPTH];
  int      ward_count = 0;
  result_t pending_results [$];
  row_t    plan [$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      steady = 1'b0;
  bit      hold_request = 1'b0;

  sorted_priority_queue_unit #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_patient_id (in_patient_id),
    .in_age        (in_age),
    .in_organ      (in_organ),
    .in_severity   (in_severity),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_patient_id(out_patient_id),
    .out_age       (out_age),
    .out_organ     (out_organ),
    .out_severity  (out_severity),
    .out_occupancy (out_occupancy)
  );

  always #1 clk = ~clk;

  function automatic result_t triage_apply(item_t it);
    result_t r;
    int pos;
    r = '0;
    r.status = ST_OK;
    case (it.mode)
      MODE_INSERT: begin
        if (ward_count >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < ward_count && ward[pos].severity > it.rec.severity) pos++;
          for (int i = ward_count; i > pos; i--) ward[i] = ward[i-1];
          ward[pos] = it.rec;
          ward_count++;
        end
      end
      MODE_REMOVE: begin
        if (ward_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.rec = ward[0];
          for (int i = 1; i < ward_count; i++) ward[i-1] = ward[i];
          ward_count--;
        end
      end
      MODE_CLEAR: begin
        ward_count = 0;
      end
      default: ;
    endcase
    r.occupancy = 5'(ward_count);
    return r;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected item", got.status, 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.status != want.status) report_mismatch("status", got.status, want.status);
    if (got.rec.patient_id != want.rec.patient_id)
      report_mismatch("patient_id", got.rec.patient_id, want.rec.patient_id);
    if (got.rec.age != want.rec.age) report_mismatch("age", got.rec.age, want.rec.age);
    if (got.rec.organ != want.rec.organ)
      report_mismatch("organ", got.rec.organ, want.rec.organ);
    if (got.rec.severity != want.rec.severity)
      report_mismatch("severity", got.rec.severity, want.rec.severity);
    if (got.occupancy != want.occupancy)
      report_mismatch("occupancy", got.occupancy, want.occupancy);
  endtask

  task automatic add_row(logic [1:0] mode, logic [15:0] pid, logic [6:0] age,
                         logic [7:0] organ, logic [7:0] sev, bit typed,
                         logic [1:0] st, logic [4:0] occ);
    row_t row;
    row.item.mode           = mode;
    row.item.rec.patient_id = pid;
    row.item.rec.age        = age;
    row.item.rec.organ      = organ;
    row.item.rec.severity   = sev;
    row.typed               = typed;
    row.want                = '0;
    row.want.status         = st;
    row.want.occupancy      = occ;
    plan.push_back(row);
  endtask

  task automatic send_item(item_t it, bit typed, result_t typed_want);
    result_t predicted;
    if (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(99) < 27);
    end
    in_valid      <= 1'b1;
    in_mode       <= it.mode;
    in_patient_id <= it.rec.patient_id;
    in_age        <= it.rec.age;
    in_organ      <= it.rec.organ;
    in_severity   <= it.rec.severity;
    do @(posedge clk); while (!in_ready);
    predicted = triage_apply(it);
    pending_results.push_back(typed ? typed_want : predicted);
  endtask

  // result side
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status         = out_status;
      got.rec.patient_id = out_patient_id;
      got.rec.age        = out_age;
      got.rec.organ      = out_organ;
      got.rec.severity   = out_severity;
      got.occupancy      = out_occupancy;
      check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    item_t it;
    bit    fill_phase;
    int    roll;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_mode       <= MODE_INSERT;
    in_patient_id <= '0;
    in_age        <= '0;
    in_organ      <= '0;
    in_severity   <= '0;
    fill_phase    = 1'b1;

    // directed table
    add_row(MODE_REMOVE, 16'h0000, 7'h00, 8'h00, 8'h00, 1, ST_EMPTY, 5'd0);
    add_row(MODE_CLEAR,  16'hFFFF, 7'h7F, 8'hFF, 8'hFF, 1, ST_OK,    5'd0);
    add_row(MODE_UNUSED, 16'hFFFF, 7'h7F, 8'hFF, 8'hFF, 1, ST_OK,    5'd0);
    add_row(MODE_INSERT, 16'hFFFF, 7'h7F, 8'hFF, 8'hFF, 1, ST_OK,    5'd1);
    add_row(MODE_INSERT, 16'h0000, 7'h00, 8'h00, 8'h00, 1, ST_OK,    5'd2);
    add_row(MODE_INSERT, 16'h1234, 7'h2A, 8'h11, 8'hFF, 0, ST_OK,    5'd0);
    add_row(MODE_REMOVE, 16'hBEEF, 7'h55, 8'hAA, 8'h33, 0, ST_OK,    5'd0);
    for (int k = 0; k < 14; k++)
      add_row(MODE_INSERT, 16'hA5A5 ^ 16'(k), 7'(k * 9), 8'(k * 17),
              (k % 3 == 0) ? 8'h80 : 8'(k * 53), 0, ST_OK, 5'd0);
    add_row(MODE_INSERT, 16'h5A5A, 7'h40, 8'h01, 8'hFF, 1, ST_FULL,  5'd16);
    add_row(MODE_UNUSED, 16'h0001, 7'h01, 8'h01, 8'h01, 1, ST_OK,    5'd16);
    add_row(MODE_REMOVE, 16'h0000, 7'h00, 8'h00, 8'h00, 0, ST_OK,    5'd0);
    add_row(MODE_CLEAR,  16'h0000, 7'h00, 8'h00, 8'h00, 1, ST_OK,    5'd0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) fill_phase = !fill_phase;
      if (n == 200) hold_request = 1'b1;
      steady = (n >= 450 && n < 600);
      roll = $urandom_range(99);
      if (fill_phase)
        it.mode = (roll < 70) ? MODE_INSERT : (roll < 94) ? MODE_REMOVE :
                  (roll < 97) ? MODE_CLEAR : MODE_UNUSED;
      else
        it.mode = (roll < 35) ? MODE_INSERT : (roll < 93) ? MODE_REMOVE :
                  (roll < 97) ? MODE_CLEAR : MODE_UNUSED;
      it.rec.patient_id = 16'($urandom);
      it.rec.age        = 7'($urandom_range(0, 127));
      it.rec.organ      = 8'($urandom);
      roll = $urandom_range(99);
      if (roll < 5)
        it.rec.severity = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else if (roll < 50)
        it.rec.severity = 8'($urandom_range(120, 123));
      else
        it.rec.severity = 8'($urandom);
      send_item(it, 1'b0, '0);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
